/* rtl/cfdzct_pkg.sv */
// ----------------------------------------------------------------------------
// cfdzct_pkg
// Shared widths, register indexes and reset values of the zero crossing timer.
// ----------------------------------------------------------------------------
package cfdzct_pkg;

  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned DELAY_W    = 5;
  localparam int unsigned INDEX_W    = 12;
  localparam int unsigned CFRAC_W    = 8;
  localparam int unsigned TIME_W     = 21;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIV_STEPS  = CFRAC_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_FRACTION = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_DELAY    = cfg_idx_t'(1);

  localparam logic [FRAC_W-1:0]  FRACTION_RESET = 16'd655;
  localparam logic [DELAY_W-1:0] DELAY_RESET    = 5'd1;
  localparam logic [FRAC_W:0]    UNITY          = 17'h10000;

endpackage

/* rtl/cfdzct_ram.sv */
// ----------------------------------------------------------------------------
// cfdzct_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module cfdzct_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/cfd_zero_crossing_timer_core.sv */
// ----------------------------------------------------------------------------
// cfd_zero_crossing_timer_core
// Constant fraction discriminator: times the first falling zero crossing of a
// pulse trace by linear interpolation.
// ----------------------------------------------------------------------------
// Each sample passes the delay-line RAM read, the multiplies, and the sum and
// sign compare before the next sample can be accepted. The sample that shows
// the crossing then runs the bit-serial divider for the 8-bit fraction and
// loads the output register; the not-found result at trace end loads the
// output register directly. A result still held in the output register holds
// the core in its output state, so no new sample is accepted until it is taken.
module cfd_zero_crossing_timer_core
  import cfdzct_pkg::*;
#(
  parameter int unsigned MAX_DELAY   = 16,
  parameter int unsigned MAX_TRACE   = 4096,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  cfg_idx_t               cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   last_sample_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   found_o,
  output logic [INDEX_W-1:0]     crossing_index_o,
  output logic [CFRAC_W-1:0]     crossing_fraction_o,
  output logic [TIME_W-1:0]      crossing_time_o
);

  localparam int unsigned AddrW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int unsigned DlyW  = $clog2(MAX_DELAY + 1);
  localparam int unsigned SumW  = DlyW + 1;
  localparam int unsigned PosW  = $clog2(MAX_TRACE + 1);
  localparam int unsigned CfdW  = SAMPLE_BITS + 20;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_DIV,
    S_OUT
  } state_e;

  state_e state_q;

  logic [FRAC_W-1:0]  fraction_q;
  logic [DELAY_W-1:0] delay_q;
  logic [AddrW-1:0]   wr_ptr_q;
  logic [PosW-1:0]    pos_q;
  logic               done_q;
  logic signed [CfdW-1:0] prev_q;
  logic signed [SAMPLE_BITS-1:0] x0_q;
  logic               out_valid_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;

  logic signed [SAMPLE_BITS-1:0] x_q;
  logic               last_q;
  logic signed [CfdW-1:0] pa_q, pb_q, xs_q;
  logic [CfdW:0]      den_q, rem_q;
  logic [CFRAC_W-1:0] quo_q;
  logic [INDEX_W-1:0] res_k_q;
  logic               res_found_q;
  logic               found_q;
  logic [INDEX_W-1:0] index_q;
  logic [CFRAC_W-1:0] cfrac_q;

  logic               in_acc;
  logic [DlyW-1:0]    dly_eff;
  logic [SumW-1:0]    rd_sum, rd_wrap;
  logic [AddrW-1:0]   raddr;
  logic               ram_we;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic               pos_lt_max, pos_ge_d, pos_eq_d, active, hit;
  logic signed [SAMPLE_BITS+16:0] mul_a;
  logic signed [SAMPLE_BITS+17:0] mul_b;
  logic signed [17:0] wgt;
  logic signed [CfdW-1:0] cur;
  logic [31:0]        k_full;
  logic [CfdW+1:0]    rem_sh;
  logic               rem_ge;
  logic               out_load;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    if (delay_q == '0) begin
      dly_eff = DlyW'(1);
    end else if (32'(delay_q) > MAX_DELAY) begin
      dly_eff = DlyW'(MAX_DELAY);
    end else begin
      dly_eff = DlyW'(delay_q);
    end
  end

  // ring read address: write pointer minus delay, wrapped
  assign rd_sum  = SumW'(wr_ptr_q) + SumW'(MAX_DELAY) - SumW'(dly_eff);
  assign rd_wrap = (rd_sum >= SumW'(MAX_DELAY)) ? rd_sum - SumW'(MAX_DELAY) : rd_sum;
  assign raddr   = rd_wrap[AddrW-1:0];

  assign pos_lt_max = 32'(pos_q) < MAX_TRACE;
  assign pos_ge_d   = 32'(pos_q) >= 32'(dly_eff);
  assign pos_eq_d   = 32'(pos_q) == 32'(dly_eff);
  assign active     = pos_lt_max && !done_q && pos_ge_d;
  assign ram_we     = (state_q == S_MUL) && pos_lt_max;

  cfdzct_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_DELAY)
  ) u_delay_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_ptr_q),
    .wdata_i(x_q),
    .re_i   (in_acc),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  assign wgt   = $signed({1'b0, UNITY - {1'b0, fraction_q}});
  assign mul_a = $signed({1'b0, fraction_q}) * x_q;
  assign mul_b = wgt * x0_q;
  assign cur   = pa_q + pb_q - xs_q;
  assign hit   = active && !pos_eq_d && !prev_q[CfdW-1] && (prev_q != '0) && cur[CfdW-1];
  assign k_full = 32'(pos_q) - 32'(dly_eff) - 32'd1;

  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fraction_q  <= FRACTION_RESET;
      delay_q     <= DELAY_RESET;
      wr_ptr_q    <= '0;
      pos_q       <= '0;
      done_q      <= 1'b0;
      prev_q      <= '0;
      x0_q        <= '0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_FRACTION: fraction_q <= cfg_data_i[FRAC_W-1:0];
          CFG_DELAY:    delay_q    <= cfg_data_i[DELAY_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (pos_lt_max) begin
            if (pos_q == '0) begin
              x0_q <= x_q;
            end
            if (wr_ptr_q == AddrW'(MAX_DELAY - 1)) begin
              wr_ptr_q <= '0;
            end else begin
              wr_ptr_q <= wr_ptr_q + 1'b1;
            end
          end
          state_q <= S_SUM;
        end
        S_SUM: begin
          if (last_q) begin
            pos_q    <= '0;
            wr_ptr_q <= '0;
            done_q   <= 1'b0;
            prev_q   <= '0;
            x0_q     <= '0;
          end else begin
            if (pos_lt_max) begin
              pos_q <= pos_q + 1'b1;
            end
            if (active) begin
              prev_q <= cur;
            end
            if (hit) begin
              done_q <= 1'b1;
            end
          end
          if (hit) begin
            div_cnt_q <= '0;
            state_q   <= S_DIV;
          end else if (last_q && !done_q) begin
            state_q <= S_OUT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_DIV: begin
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q    <= $signed(sample_i);
      last_q <= last_sample_i;
    end
    if (state_q == S_MUL) begin
      pa_q <= CfdW'(mul_a);
      pb_q <= CfdW'(mul_b);
      xs_q <= CfdW'($signed(ram_rdata)) <<< 16;
    end
    if (state_q == S_SUM) begin
      den_q       <= (CfdW + 1)'(prev_q) - (CfdW + 1)'(cur);
      rem_q       <= (CfdW + 1)'(prev_q);
      quo_q       <= '0;
      res_found_q <= hit;
      res_k_q     <= hit ? k_full[INDEX_W-1:0] : '0;
    end
    if (state_q == S_DIV) begin
      rem_q <= rem_ge ? (CfdW + 1)'(rem_sh - {1'b0, den_q}) : rem_sh[CfdW:0];
      quo_q <= {quo_q[CFRAC_W-2:0], rem_ge};
    end
    if (out_load) begin
      found_q <= res_found_q;
      index_q <= res_k_q;
      cfrac_q <= quo_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign found_o             = found_q;
  assign crossing_index_o    = index_q;
  assign crossing_fraction_o = cfrac_q;
  assign crossing_time_o     = {index_q, cfrac_q, 1'b0};

endmodule

/* rtl/cfdzct_checker.sv */
// ----------------------------------------------------------------------------
// cfdzct_checker
// Port level checks of the zero crossing timer, bound to the top level.
// ----------------------------------------------------------------------------
module cfdzct_checker
  import cfdzct_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               found_o,
  input logic [INDEX_W-1:0] crossing_index_o,
  input logic [CFRAC_W-1:0] crossing_fraction_o,
  input logic [TIME_W-1:0]  crossing_time_o
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o)
      && $stable(crossing_index_o) && $stable(crossing_fraction_o))
    else $error("stalled result changed");

  // not-found transaction carries zero fields
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> crossing_index_o == '0
      && crossing_fraction_o == '0 && crossing_time_o == '0)
    else $error("not-found result with nonzero fields");

  // time is index times 512 plus twice the fraction
  a_time_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> crossing_time_o == {crossing_index_o, crossing_fraction_o, 1'b0})
    else $error("crossing time mismatch");

  // one sample in flight at a time
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

endmodule

bind cfd_zero_crossing_timer_core cfdzct_checker u_cfdzct_checker (.*);

/* tb/sv/cfd_zero_crossing_timer_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cfd_zero_crossing_timer_core_test
// Self-checking bench for the zero crossing timer. A short table of traces
// covers extreme samples, delay clamping, traces shorter than the delay and
// the not-found result. It is followed by random pulse and noise traces
// under random register settings. Results are checked against a cycle-free
// model of the timer, or against the result typed into the table.
// ----------------------------------------------------------------------------
module cfd_zero_crossing_timer_core_test;
  import cfdzct_pkg::*;

  localparam int unsigned TAPS        = 16;
  localparam int unsigned TRACE_LEN   = 4096;
  localparam int unsigned DRAIN       = 16;
  localparam int unsigned TAIL        = 40;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned ITEM_GOAL   = 500;

  localparam cfg_idx_t CFG_SPARE = cfg_idx_t'(3);

  typedef struct packed {
    logic                found;
    logic [INDEX_W-1:0]  index;
    logic [CFRAC_W-1:0]  frac;
    logic [TIME_W-1:0]   stamp;
  } timing_t;

  localparam timing_t NOT_FOUND = '0;

  typedef enum logic [0:0] {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    cfg_idx_t   reg_idx;
    logic [15:0] value;
    logic       last;
    logic       typed;
    timing_t    want;
  } plan_row_t;

  // reset settings: fraction 655, delay 1
  localparam plan_row_t PLAN [26] = '{
    '{ROW_SAMPLE, CFG_FRACTION, 16'h8000, 1'b1, 1'b1, NOT_FOUND},
    '{ROW_SAMPLE, CFG_FRACTION, 16'h7FFF, 1'b0, 1'b0, NOT_FOUND},
    '{ROW_SAMPLE, CFG_FRACTION, 16'h7FFF, 1'b1, 1'b1, NOT_FOUND},
    '{ROW_SAMPLE, CFG_FRACTION, 16'd0,    1'b0, 1'b0, NOT_FOUND},
    '{ROW_SAMPLE, CFG_FRACTION, 16'd0,    1'b0, 1'b0, NOT_FOUND},
    '{ROW_SAMPLE, CFG_FRACTION, 16'd1000, 1'b0, 1'b0, NOT_FOUND},
    '{ROW_SAMPLE, CFG_FRACTION, 16'd0,    1'b0, 1'b0, NOT_FOUND},
    '{ROW_SAMPLE, CFG_FRACTION, 16'd5,    1'b1, 1'b0, NOT_FOUND},
    '{ROW_SAMPLE, CFG_FRACTION, 16'd100,  1'b0, 1'b0, NOT_FOUND},
    '{ROW_SAMPLE, CFG_FRACTION, 16'h7FFF, 1'b0, 1'b0, NOT_FOUND},
    '{ROW_SAMPLE, CFG_FRACTION, 16'h8000, 1'b0, 1'b0, NOT_FOUND},
    '{ROW_SAMPLE, CFG_FRACTION, 16'd0,    1'b1, 1'b0, NOT_FOUND},
    '{ROW_WRITE,  CFG_FRACTION, 16'd0,    1'b0, 1'b0, NOT_FOUND},
    '{ROW_WRITE,  CFG_DELAY,    16'd0,    1'b0, 1'b0, NOT_FOUND},
    '{ROW_SAMPLE, CFG_FRACTION, 16'd20000, 1'b0, 1'b0, NOT_FOUND},
    '{ROW_SAMPLE, CFG_FRACTION, 16'd20000, 1'b0, 1'b0, NOT_FOUND},
    '{ROW_SAMPLE, CFG_FRACTION, 16'hFF9C, 1'b0, 1'b0, NOT_FOUND},
    '{ROW_SAMPLE, CFG_FRACTION, 16'd300,  1'b1, 1'b0, NOT_FOUND},
    '{ROW_WRITE,  CFG_FRACTION, 16'hFFFF, 1'b0, 1'b0, NOT_FOUND},
    '{ROW_WRITE,  CFG_DELAY,    16'hFFFF, 1'b0, 1'b0, NOT_FOUND},
    '{ROW_SAMPLE, CFG_FRACTION, 16'hFFFF, 1'b0, 1'b0, NOT_FOUND},
    '{ROW_SAMPLE, CFG_FRACTION, 16'h7FFF, 1'b0, 1'b0, NOT_FOUND},
    '{ROW_SAMPLE, CFG_FRACTION, 16'h8000, 1'b1, 1'b1, NOT_FOUND},
    '{ROW_WRITE,  CFG_SPARE,    16'h5A5A, 1'b0, 1'b0, NOT_FOUND},
    '{ROW_WRITE,  CFG_DELAY,    16'd17,   1'b0, 1'b0, NOT_FOUND},
    '{ROW_SAMPLE, CFG_FRACTION, 16'h0001, 1'b1, 1'b1, NOT_FOUND}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  cfg_idx_t              cfg_index_i   = CFG_FRACTION;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic [15:0]           sample_i      = '0;
  logic                  last_sample_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic                  found_o;
  logic [INDEX_W-1:0]    crossing_index_o;
  logic [CFRAC_W-1:0]    crossing_fraction_o;
  logic [TIME_W-1:0]     crossing_time_o;

  // timer model state
  logic [FRAC_W-1:0]  cfg_fraction  = FRACTION_RESET;
  logic [DELAY_W-1:0] cfg_delay     = DELAY_RESET;
  longint             tap_ring [TAPS];
  longint             first_sample  = 0;
  longint             last_cfd      = 0;
  int unsigned        sample_pos    = 0;
  bit                 crossing_seen = 1'b0;

  timing_t     timing_q [$];
  timing_t     oldest;
  int unsigned errors       = 0;
  int unsigned stall_cycles = 0;
  bit          idle_on      = 1'b1;

  cfd_zero_crossing_timer_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .sample_i           (sample_i),
    .last_sample_i      (last_sample_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .found_o            (found_o),
    .crossing_index_o   (crossing_index_o),
    .crossing_fraction_o(crossing_fraction_o),
    .crossing_time_o    (crossing_time_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, exp);
    errors++;
  endtask

  // advances the model by one sample, returns 1 when a result is due
  function automatic bit forecast(input logic [15:0] s, input logic l, output timing_t r);
    int unsigned d;
    int unsigned k;
    longint      x;
    longint      xd;
    longint      cur;
    longint      quo;
    longint      tm;
    bit          hit;
    hit = 1'b0;
    r   = '0;
    d   = cfg_delay;
    if (d < 1) d = 1;
    if (d > TAPS) d = TAPS;
    x = longint'($signed(s));
    if (sample_pos < TRACE_LEN) begin
      if (sample_pos == 0) first_sample = x;
      if (!crossing_seen && sample_pos >= d) begin
        xd  = tap_ring[(sample_pos - d) % TAPS];
        cur = longint'(cfg_fraction) * x - xd * 65536
            + longint'(UNITY - cfg_fraction) * first_sample;
        if (sample_pos == d) begin
          last_cfd = cur;
        end else begin
          if (last_cfd > 0 && cur < 0) begin
            quo = (last_cfd * 256) / (last_cfd - cur);
            k   = sample_pos - d - 1;
            tm  = longint'(k) * 512 + longint'(quo[7:0]) * 2;
            r.found = 1'b1;
            r.index = k[INDEX_W-1:0];
            r.frac  = quo[CFRAC_W-1:0];
            r.stamp = tm[TIME_W-1:0];
            hit = 1'b1;
            crossing_seen = 1'b1;
          end
          last_cfd = cur;
        end
      end
      tap_ring[sample_pos % TAPS] = x;
      sample_pos++;
    end
    if (l) begin
      if (!crossing_seen) begin
        r   = NOT_FOUND;
        hit = 1'b1;
      end
      first_sample  = 0;
      last_cfd      = 0;
      sample_pos    = 0;
      crossing_seen = 1'b0;
    end
    return hit;
  endfunction

  function automatic logic [15:0] pick_delay();
    logic [15:0] w;
    w = 16'($urandom_range(0, 65535)) & 16'hFFE0;
    case ($urandom_range(0, 9))
      0: w[4:0] = 5'd0;
      1: w[4:0] = 5'd31;
      2: w[4:0] = 5'd17;
      default: w[4:0] = 5'($urandom_range(1, 16));
    endcase
    return w;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic push_sample(input logic [15:0] s, input logic l, input logic typed,
                             input timing_t want);
    timing_t r;
    bit      due;
    while (idle_on && $urandom_range(0, 99) < 8) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_i      <= s;
    last_sample_i <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    due = forecast(s, l, r);
    if (typed) timing_q.push_back(want);
    else if (due) timing_q.push_back(r);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] data);
    in_valid_i <= 1'b0;
    while (timing_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_FRACTION: cfg_fraction = data;
      CFG_DELAY:    cfg_delay    = data[DELAY_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= !idle_on || ($urandom_range(0, 99) >= 8);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (timing_q.size() == 0) begin
        report_mismatch("unexpected result, found", found_o, 0);
      end else begin
        oldest = timing_q.pop_front();
        if (found_o !== oldest.found)
          report_mismatch("found", found_o, oldest.found);
        if (crossing_index_o !== oldest.index)
          report_mismatch("crossing_index", crossing_index_o, oldest.index);
        if (crossing_fraction_o !== oldest.frac)
          report_mismatch("crossing_fraction", crossing_fraction_o, oldest.frac);
        if (crossing_time_o !== oldest.stamp)
          report_mismatch("crossing_time", crossing_time_o, oldest.stamp);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("FAIL cfd_zero_crossing_timer_core");
      $finish;
    end
  end

  initial begin
    int unsigned items;
    int unsigned traces;
    int          kind;
    int          len;
    int          t0;
    int          rise;
    int          amp;
    int          tail;
    int          base;
    int          noise_amp;
    int          mid_at;
    int          v;
    items  = 0;
    traces = 0;
    foreach (tap_ring[i]) tap_ring[i] = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        write_reg(PLAN[i].reg_idx, PLAN[i].value);
      end else begin
        push_sample(PLAN[i].value, PLAN[i].last, PLAN[i].typed, PLAN[i].want);
      end
    end

    while (items < ITEM_GOAL) begin
      idle_on = !(traces >= 16 && traces < 24);
      if (traces == 0 || $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0: write_reg(CFG_FRACTION, 16'd0);
          1: write_reg(CFG_FRACTION, 16'hFFFF);
          2: write_reg(CFG_FRACTION, 16'($urandom_range(0, 65535)));
          default: write_reg(CFG_FRACTION, 16'($urandom_range(6000, 40000)));
        endcase
        write_reg(CFG_DELAY, pick_delay());
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        base      = int'($urandom_range(0, 4000)) - 2000;
        amp       = int'($urandom_range(500, 30000));
        len       = $urandom_range(8, 40);
        t0        = $urandom_range(1, 8);
        rise      = $urandom_range(1, 4);
        noise_amp = $urandom_range(0, 1) ? 0 : int'($urandom_range(1, 50));
        mid_at    = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, len - 1)) : -1;
        if ($urandom_range(0, 9) == 0) amp = -amp;
        tail = 0;
        for (int j = 0; j < len; j++) begin
          if (j == mid_at) write_reg(CFG_DELAY, pick_delay());
          if (j < t0) begin
            v = base;
          end else if (j < t0 + rise) begin
            v    = base + amp * (j - t0 + 1) / rise;
            tail = amp;
          end else begin
            tail = tail * 3 / 4;
            v    = base + tail;
          end
          if (noise_amp != 0) v = v + int'($urandom_range(0, 2 * noise_amp)) - noise_amp;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          push_sample(v[15:0], j == len - 1, 1'b0, NOT_FOUND);
          items++;
        end
      end else begin
        len = $urandom_range(1, 30);
        for (int j = 0; j < len; j++) begin
          case ($urandom_range(0, 7))
            0: v = -32768;
            1: v = 32767;
            default: v = int'($urandom_range(0, 65535));
          endcase
          push_sample(v[15:0], j == len - 1, 1'b0, NOT_FOUND);
          items++;
        end
      end
      traces++;
    end

    in_valid_i <= 1'b0;
    while (timing_q.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS cfd_zero_crossing_timer_core");
    end else begin
      $display("FAIL cfd_zero_crossing_timer_core");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/cfdzct_pkg.sv
rtl/cfdzct_ram.sv
rtl/cfd_zero_crossing_timer_core.sv
rtl/cfdzct_checker.sv
tb/sv/cfd_zero_crossing_timer_core_test.sv
